FILE: rtl/core/first_fit_block_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by modules that assert.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FFBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FFBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/ffba_pkg.sv
// Package for the first-fit block allocator: types, constants, state codes.
// Depends on nothing.
`default_nettype none
package ffba_pkg;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 24;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_BAD    = 2'd2
    } status_t;

    localparam logic [0:0] REG_START = 1'b0;
    localparam logic [0:0] REG_END   = 1'b1;

    typedef struct packed {
        op_t         op;
        logic [31:0] request_bytes;
        logic [31:0] free_address;
    } in_item_t;

    typedef struct packed {
        logic [31:0] payload_address;
        status_t     status;
    } out_item_t;

    typedef enum logic [3:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_RD,
        FSM_CHECK,
        FSM_SHIFT_RD,
        FSM_SHIFT_WR,
        FSM_DONE
    } fsm_t;
endpackage
`default_nettype wire

FILE: rtl/core/first_fit_block_allocator.sv
// Top level of the first-fit block allocator with coalescing.
// Depends on ffba_pkg and first_fit_block_allocator_macros.svh.
//
//  channel   | handshake             | payload
//  cmd       | start & !busy         | cmd (in_item_t)
//  result    | done strobe, 1 cycle  | result (out_item_t)
//  config    | APB write access      | region_start, region_end
//
// Allocate and free walk the block table one entry at a time (memory read,
// then compare). A split or a merge then moves the table tail one entry at
// a time through the single table memory (read, then write).
// After reset and after each region register write made while idle or
// clearing, a clearing pass writes the first block and the end marker;
// busy stays high throughout.
// Results cannot be stalled; done pulses once per accepted command.
`default_nettype none
`include "first_fit_block_allocator_macros.svh"
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire ffba_pkg::in_item_t  cmd,
    output logic                     done,
    output ffba_pkg::out_item_t      result,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [32:0] HDR = 33'(HEADER_BYTES);
    localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);

    // Table memory: start address and used mark per entry
    logic [32:0] mem [MAX_BLOCKS];
    logic [32:0] rdata_reg;

    logic [31:0] rstart_reg, rend_reg;
    ffba_pkg::fsm_t state_reg, state_next;
    ffba_pkg::fsm_t state_after_check, state_after_shift;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] sidx_reg, sidx_next;     // shift cursor / end
    logic          sdir_reg, sdir_next;     // 1 insert (move up), 0 remove
    logic [32:0]   cur_reg, cur_next;       // current entry {used, start}
    logic          have_cur_reg, have_cur_next;
    logic [32:0]   prev_reg, prev_next;     // previous entry
    logic [2:0]    phase_reg, phase_next;   // sub-step within an operation
    logic [CW-1:0] hit_reg, hit_next;
    ffba_pkg::in_item_t  item_reg, item_next;
    ffba_pkg::out_item_t res_reg, res_next;
    logic [32:0]   ins_reg, ins_next;       // entry held for insert shift
    logic          done_reg, done_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [32:0]   wdata;
    logic          cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ffba_pkg::REG_END) ? rend_reg : rstart_reg;
    assign busy   = (state_reg != ffba_pkg::FSM_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // Region registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rstart_reg <= 32'd0;
            rend_reg   <= 32'd65536;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ffba_pkg::REG_START)
                rstart_reg <= pwdata;
            else
                rend_reg <= pwdata;
        end
    end

    // Memory with registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffba_pkg::FSM_CLEAR;
            cnt_reg   <= CW'(2);
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        sidx_reg     <= sidx_next;
        sdir_reg     <= sdir_next;
        cur_reg      <= cur_next;
        have_cur_reg <= have_cur_next;
        prev_reg     <= prev_next;
        phase_reg    <= phase_next;
        hit_reg      <= hit_next;
        item_reg     <= item_next;
        res_reg      <= res_next;
        ins_reg      <= ins_next;
    end

    // Shared size/compare unit
    logic [32:0] span, need, rem, pay;
    logic        fits, split_ok;
    always_comb
    begin
        span = (rdata_reg[31:0] >= cur_reg[31:0])
             ? {1'b0, rdata_reg[31:0] - cur_reg[31:0]} : 33'd0;
        need = {1'b0, item_reg.request_bytes} + HDR;
        rem  = span - need;
        fits = !cur_reg[32] && (span >= need);
        split_ok = fits && (rem > HDR) && (cnt_reg < CMAX);
        pay  = {1'b0, cur_reg[31:0]} + HDR;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffba_pkg::FSM_CLEAR:
                if (!cfg_wr && idx_reg == CW'(1))
                    state_next = ffba_pkg::FSM_IDLE;
            ffba_pkg::FSM_IDLE:
                if (cfg_wr)
                    state_next = ffba_pkg::FSM_CLEAR;
                else if (start)
                    state_next = ffba_pkg::FSM_RD;
            ffba_pkg::FSM_RD:
                state_next = ffba_pkg::FSM_CHECK;
            ffba_pkg::FSM_CHECK:
                state_next = state_after_check;
            ffba_pkg::FSM_SHIFT_RD:
                state_next = ffba_pkg::FSM_SHIFT_WR;
            ffba_pkg::FSM_SHIFT_WR:
                state_next = state_after_shift;
            ffba_pkg::FSM_DONE:
                state_next = ffba_pkg::FSM_IDLE;
            default:
                state_next = ffba_pkg::FSM_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        sidx_next     = sidx_reg;
        sdir_next     = sdir_reg;
        cur_next      = cur_reg;
        have_cur_next = have_cur_reg;
        prev_next     = prev_reg;
        phase_next    = phase_reg;
        hit_next      = hit_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        ins_next      = ins_reg;
        done_next     = 1'b0;
        we            = 1'b0;
        waddr         = idx_reg[IW-1:0];
        wdata         = '0;
        raddr         = idx_reg[IW-1:0];
        state_after_check = ffba_pkg::FSM_RD;
        state_after_shift = ffba_pkg::FSM_SHIFT_RD;
        unique case (state_reg)
            ffba_pkg::FSM_CLEAR:
            begin
                // Write end marker then first block
                we = 1'b1;
                if (idx_reg == CW'(0))
                begin
                    waddr = IW'(1);
                    wdata = {1'b1, rend_reg - 32'(HEADER_BYTES)};
                    idx_next = CW'(1);
                end
                else
                begin
                    waddr = '0;
                    wdata = {1'b0, rstart_reg};
                    idx_next = '0;
                end
                // Restart the pass when a region register changes meanwhile
                if (cfg_wr)
                    idx_next = '0;
                cnt_next = CW'(2);
            end
            ffba_pkg::FSM_IDLE:
            begin
                idx_next = '0;
                if (cfg_wr)
                    idx_next = '0;
                else if (start)
                begin
                    item_next     = cmd;
                    have_cur_next = 1'b0;
                    prev_next     = {1'b1, 32'd0};
                    phase_next    = 3'd0;
                    raddr         = '0;
                end
            end
            ffba_pkg::FSM_RD:
            begin
                // Read pending on raddr = idx; data valid next cycle
                raddr = idx_reg[IW-1:0];
            end
            ffba_pkg::FSM_CHECK:
            begin
                // rdata_reg holds entry idx; cur_reg holds entry idx-1
                if (item_reg.op == ffba_pkg::OP_ALLOC)
                begin
                    if (!have_cur_reg)
                    begin
                        cur_next = rdata_reg;
                        have_cur_next = 1'b1;
                        idx_next = idx_reg + CW'(1);
                        raddr = idx_next[IW-1:0];
                        if (idx_reg + CW'(1) >= cnt_reg)
                        begin
                            res_next = '{32'd0, ffba_pkg::ST_NO_FIT};
                            state_after_check = ffba_pkg::FSM_DONE;
                        end
                    end
                    else if (fits)
                    begin
                        // Mark used; split if room
                        we = 1'b1;
                        waddr = IW'(idx_reg - CW'(1));
                        wdata = {1'b1, cur_reg[31:0]};
                        res_next = '{pay[31:0], ffba_pkg::ST_DONE};
                        if (split_ok)
                        begin
                            ins_next  = {1'b0, cur_reg[31:0] + need[31:0]};
                            sidx_next = idx_reg;
                            idx_next  = cnt_reg;
                            sdir_next = 1'b1;
                            cnt_next  = cnt_reg + CW'(1);
                            state_after_check = ffba_pkg::FSM_SHIFT_RD;
                        end
                        else
                            state_after_check = ffba_pkg::FSM_DONE;
                    end
                    else
                    begin
                        cur_next = rdata_reg;
                        idx_next = idx_reg + CW'(1);
                        raddr = idx_next[IW-1:0];
                        if (idx_reg + CW'(1) >= cnt_reg)
                        begin
                            res_next = '{32'd0, ffba_pkg::ST_NO_FIT};
                            state_after_check = ffba_pkg::FSM_DONE;
                        end
                    end
                end
                else
                begin
                    // Free: phase 0 search, 1 look at next and merge
                    priority if (phase_reg == 3'd0)
                    begin
                        if (idx_reg + CW'(1) >= cnt_reg)
                        begin
                            res_next = '{32'd0, ffba_pkg::ST_BAD};
                            state_after_check = ffba_pkg::FSM_DONE;
                        end
                        else if (rdata_reg[32] && (rdata_reg[31:0] + 32'(HEADER_BYTES))
                                 == item_reg.free_address)
                        begin
                            we = 1'b1;
                            wdata = {1'b0, rdata_reg[31:0]};
                            hit_next = idx_reg;
                            cur_next = prev_reg;
                            phase_next = 3'd1;
                            idx_next = idx_reg + CW'(1);
                            raddr = idx_next[IW-1:0];
                        end
                        else
                        begin
                            prev_next = rdata_reg;
                            idx_next = idx_reg + CW'(1);
                            raddr = idx_next[IW-1:0];
                        end
                    end
                    else
                    begin
                        // rdata_reg = entry hit+1; cur_reg = entry hit-1
                        res_next = '{32'd0, ffba_pkg::ST_DONE};
                        phase_next = 3'd0;
                        if (hit_reg != '0 && !cur_reg[32])
                        begin
                            // Remove hit, and hit+1 too if free
                            sidx_next = hit_reg;
                            sdir_next = 1'b0;
                            if (!rdata_reg[32])
                            begin
                                idx_next = hit_reg + CW'(2);
                                cnt_next = cnt_reg - CW'(2);
                            end
                            else
                            begin
                                idx_next = hit_reg + CW'(1);
                                cnt_next = cnt_reg - CW'(1);
                            end
                            state_after_check = ffba_pkg::FSM_SHIFT_RD;
                        end
                        else if (!rdata_reg[32])
                        begin
                            sidx_next = hit_reg + CW'(1);
                            sdir_next = 1'b0;
                            idx_next  = hit_reg + CW'(2);
                            cnt_next  = cnt_reg - CW'(1);
                            state_after_check = ffba_pkg::FSM_SHIFT_RD;
                        end
                        else
                            state_after_check = ffba_pkg::FSM_DONE;
                    end
                end
            end
            ffba_pkg::FSM_SHIFT_RD:
            begin
                // Insert: idx walks down from old count; remove: src idx
                if (sdir_reg)
                    raddr = IW'(idx_reg - CW'(1));
                else
                    raddr = idx_reg[IW-1:0];
            end
            ffba_pkg::FSM_SHIFT_WR:
            begin
                we = 1'b1;
                if (sdir_reg)
                begin
                    if (idx_reg == sidx_reg)
                    begin
                        waddr = idx_reg[IW-1:0];
                        wdata = ins_reg;
                        state_after_shift = ffba_pkg::FSM_DONE;
                    end
                    else
                    begin
                        waddr = idx_reg[IW-1:0];
                        wdata = rdata_reg;
                        idx_next = idx_reg - CW'(1);
                    end
                end
                else
                begin
                    waddr = sidx_reg[IW-1:0];
                    wdata = rdata_reg;
                    sidx_next = sidx_reg + CW'(1);
                    idx_next  = idx_reg + CW'(1);
                    if (sidx_reg + CW'(1) >= cnt_reg)
                        state_after_shift = ffba_pkg::FSM_DONE;
                end
            end
            ffba_pkg::FSM_DONE:
            begin
                done_next = 1'b1;
                phase_next = 3'd0;
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    `FFBA_ASSERT_IMP(a_done_idle, clk, rst_n, done, state_reg == ffba_pkg::FSM_IDLE,
        "result strobe outside idle")
    `FFBA_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg >= CW'(2) && cnt_reg <= CMAX,
        "block count out of range")
    `FFBA_ASSERT_NXT(a_start_busy, clk, rst_n,
        start && !busy && !cfg_wr, busy, "accepted command did not raise busy")
    `FFBA_ASSERT_IMP(a_status_code, clk, rst_n, done,
        result.status == ffba_pkg::ST_DONE || result.status == ffba_pkg::ST_NO_FIT
        || result.status == ffba_pkg::ST_BAD, "bad status code")
endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for first_fit_block_allocator: directed table, then random phases.
// Depends on ffba_pkg and the allocator RTL; predicts every result with its own block table.
`default_nettype none
module tb;
    localparam int  TABLE_DEPTH = ffba_pkg::MAX_BLOCKS_DEF;
    localparam int  HDR         = ffba_pkg::HEADER_BYTES_DEF;
    localparam int  ITEMS       = 1750;
    localparam int  PHASES      = 7;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    ffba_pkg::in_item_t  cmd;
    logic                done;
    ffba_pkg::out_item_t result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    first_fit_block_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow heap: region registers and the block table
    logic [31:0] heap_start_reg;
    logic [31:0] heap_end_reg;
    logic [31:0] blk_start [TABLE_DEPTH];
    bit          blk_used  [TABLE_DEPTH];
    int          blk_count;

    ffba_pkg::out_item_t pending_results[$];
    logic [31:0]         live_payloads[$];
    int                  error_count;
    longint              cycle_count;
    int                  sender_gap_pct;

    typedef struct {
        ffba_pkg::op_t       op;
        logic [31:0]         req;
        logic [31:0]         addr;
        bit                  known;
        ffba_pkg::out_item_t want;
    } stim_row_t;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // Rebuild the heap as one free block plus the end marker
    function automatic void rebuild_heap();
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            blk_start[j] = '0;
            blk_used[j]  = 1'b0;
        end
        blk_start[0] = heap_start_reg;
        blk_used[0]  = 1'b0;
        blk_start[1] = heap_end_reg - 32'(HDR);
        blk_used[1]  = 1'b1;
        blk_count    = 2;
    endfunction

    function automatic void drop_entry(input int k);
        for (int j = k; j < blk_count - 1; j++)
        begin
            blk_start[j] = blk_start[j+1];
            blk_used[j]  = blk_used[j+1];
        end
        blk_count--;
    endfunction

    // Compute the result of one command and update the shadow heap
    function automatic ffba_pkg::out_item_t allocator_outcome(input ffba_pkg::in_item_t c);
        ffba_pkg::out_item_t r;
        logic [63:0]         need;
        logic [63:0]         span;
        int                  i;
        r.payload_address = '0;
        r.status          = ffba_pkg::ST_DONE;
        if (c.op == ffba_pkg::OP_ALLOC)
        begin
            need = {32'd0, c.request_bytes} + 64'(HDR);
            for (i = 0; i + 1 < blk_count; i++)
            begin
                span = (blk_start[i+1] >= blk_start[i]) ?
                       64'(blk_start[i+1] - blk_start[i]) : 64'd0;
                if (blk_used[i] || span < need)
                    continue;
                blk_used[i] = 1'b1;
                // split off the remainder if it exceeds a header and the table is not full
                if (span - need > 64'(HDR) && blk_count < TABLE_DEPTH)
                begin
                    for (int j = blk_count; j > i + 1; j--)
                    begin
                        blk_start[j] = blk_start[j-1];
                        blk_used[j]  = blk_used[j-1];
                    end
                    blk_start[i+1] = blk_start[i] + need[31:0];
                    blk_used[i+1]  = 1'b0;
                    blk_count++;
                end
                r.payload_address = blk_start[i] + 32'(HDR);
                return r;
            end
            r.status = ffba_pkg::ST_NO_FIT;
            return r;
        end
        for (i = 0; i + 1 < blk_count; i++)
            if (blk_start[i] + 32'(HDR) == c.free_address && blk_used[i])
                break;
        if (i + 1 >= blk_count)
        begin
            r.status = ffba_pkg::ST_BAD;
            return r;
        end
        blk_used[i] = 1'b0;
        // merge with free neighbors
        if (i > 0 && !blk_used[i-1])
        begin
            drop_entry(i);
            i--;
        end
        if (i + 1 < blk_count && !blk_used[i+1])
            drop_entry(i + 1);
        return r;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no command outstanding");
            else
            begin
                ffba_pkg::out_item_t want;
                want = pending_results.pop_front();
                if (result.payload_address !== want.payload_address)
                    report_mismatch($sformatf("payload_address got %h want %h",
                        result.payload_address, want.payload_address));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                        result.status, want.status));
            end
        end
    end

    // Drive one command, hold it until accepted, record the expectation
    task automatic send_command(input ffba_pkg::in_item_t c, input bit known,
                                input ffba_pkg::out_item_t typed);
        ffba_pkg::out_item_t predicted;
        int                  gap;
        gap = 0;
        if ($urandom_range(99, 0) < sender_gap_pct)
            gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        predicted = allocator_outcome(c);
        pending_results.push_back(known ? typed : predicted);
        if (c.op == ffba_pkg::OP_ALLOC && predicted.status == ffba_pkg::ST_DONE)
            live_payloads.push_back(predicted.payload_address);
    endtask

    // Hold until the block is idle with nothing outstanding
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Write one region register, read it back, wait out the restart
    task automatic write_region(input logic [0:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready !== 1'b1)
            report_mismatch("pready low on access");
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (prdata !== value)
            report_mismatch($sformatf("region readback got %h want %h", prdata, value));
        while (busy)
            @(posedge clk);
        if (idx == ffba_pkg::REG_START)
            heap_start_reg = value;
        else
            heap_end_reg = value;
        rebuild_heap();
        live_payloads.delete();
    endtask

    initial
    begin
        stim_row_t           directed[];
        logic [31:0]         region_lo[PHASES];
        logic [31:0]         region_hi[PHASES];
        ffba_pkg::in_item_t  c;
        ffba_pkg::out_item_t none;
        int                  per_phase;
        int                  k;

        // Region settings: default, small, degenerate, wrapped end, full span, tiny, default
        region_lo = '{32'd0, 32'd1000, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'h100, 32'd0};
        region_hi = '{32'd65536, 32'd5000, 32'd0, 32'd10, 32'hFFFF_FFFF, 32'h148, 32'd65536};

        none = '{payload_address: 32'd0, status: ffba_pkg::ST_DONE};
        directed = '{
            '{ffba_pkg::OP_ALLOC, 32'd0,         32'd0,         1,
              '{32'd24, ffba_pkg::ST_DONE}},
            '{ffba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
              '{32'd0, ffba_pkg::ST_NO_FIT}},
            '{ffba_pkg::OP_FREE,  32'hFFFF_FFFF, 32'd0,         1,
              '{32'd0, ffba_pkg::ST_BAD}},
            '{ffba_pkg::OP_FREE,  32'd0,         32'hFFFF_FFFF, 1,
              '{32'd0, ffba_pkg::ST_BAD}},
            '{ffba_pkg::OP_FREE,  32'd0,         32'd65536,     1,
              '{32'd0, ffba_pkg::ST_BAD}},
            '{ffba_pkg::OP_FREE,  32'd0,         32'd24,        1,
              '{32'd0, ffba_pkg::ST_DONE}},
            '{ffba_pkg::OP_FREE,  32'd0,         32'd24,        1,
              '{32'd0, ffba_pkg::ST_BAD}},
            '{ffba_pkg::OP_ALLOC, 32'd100,       32'd0,         0, none},
            '{ffba_pkg::OP_ALLOC, 32'd65000,     32'd0,         0, none},
            '{ffba_pkg::OP_ALLOC, 32'd0,         32'd0,         0, none},
            '{ffba_pkg::OP_ALLOC, 32'd400,       32'd0,         0, none},
            '{ffba_pkg::OP_FREE,  32'd0,         32'd24,        0, none},
            '{ffba_pkg::OP_FREE,  32'd0,         32'd148,       0, none},
            '{ffba_pkg::OP_ALLOC, 32'd65124,     32'd0,         0, none},
            '{ffba_pkg::OP_FREE,  32'd0,         32'd65172,     0, none},
            '{ffba_pkg::OP_FREE,  32'd0,         32'd24,        0, none},
            '{ffba_pkg::OP_ALLOC, 32'd65464,     32'd0,         0, none}
        };

        // Known values on every input, then reset
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        error_count    = 0;
        cycle_count    = 0;
        sender_gap_pct = 0;
        heap_start_reg = 32'd0;
        heap_end_reg   = 32'd65536;
        rebuild_heap();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed[r])
        begin
            c.op            = directed[r].op;
            c.request_bytes = directed[r].req;
            c.free_address  = directed[r].addr;
            send_command(c, directed[r].known, directed[r].want);
        end
        wait_idle();
        write_region(ffba_pkg::REG_START, 32'd0);
        live_payloads.delete();

        per_phase = ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            // Restart the heap only while idle
            if (p > 0)
            begin
                wait_idle();
                write_region(ffba_pkg::REG_START, region_lo[p]);
                write_region(ffba_pkg::REG_END, region_hi[p]);
            end
            case (p % 4)
                1:       sender_gap_pct = 52;
                3:       sender_gap_pct = 8;
                default: sender_gap_pct = 0;
            endcase
            for (int n = 0; n < per_phase; n++)
            begin
                c.request_bytes = $urandom();
                c.free_address  = $urandom();
                // Mostly allocs and frees of live blocks, some bad frees
                if (live_payloads.size() == 0 || $urandom_range(99, 0) < 55)
                begin
                    c.op = ffba_pkg::OP_ALLOC;
                    case ($urandom_range(9, 0))
                        0:       c.request_bytes = $urandom();
                        1, 2:    c.request_bytes = $urandom_range(4000, 0);
                        3:       c.request_bytes = 32'd0;
                        default: c.request_bytes = $urandom_range(200, 0);
                    endcase
                end
                else
                begin
                    c.op = ffba_pkg::OP_FREE;
                    if ($urandom_range(9, 0) != 0)
                    begin
                        k = $urandom_range(live_payloads.size() - 1, 0);
                        c.free_address = live_payloads[k];
                        live_payloads.delete(k);
                    end
                end
                send_command(c, 1'b0, none);
            end
        end

        // Drain, then let the block settle
        wait_idle();
        repeat (400) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("expected results never arrived");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
